/* hdl/ffa_pkg.sv */
`timescale 1ns / 1ps

package ffa_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_SLOTS    = 64;
    localparam int DEF_ADDRESS_BITS = 16;
    localparam logic [15:0] RESET_MEMORY_SIZE = 16'd1024;

    // Widest values carried on the hole command and view buses
    localparam int POS_W  = 9;
    localparam int DATA_W = 32;

    // Stream payload widths
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 40;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_EVICTED = 2'd1;
    localparam logic [1:0] ST_FREED   = 2'd2;
    localparam logic [1:0] ST_ERROR   = 2'd3;

    // Hole cell operations
    localparam logic [2:0] OP_HOLD       = 3'd0;
    localparam logic [2:0] OP_INIT       = 3'd1;
    localparam logic [2:0] OP_INSERT     = 3'd2;
    localparam logic [2:0] OP_DELETE     = 3'd3;
    localparam logic [2:0] OP_SHRINK     = 3'd4;
    localparam logic [2:0] OP_MERGE_DOWN = 3'd5;
    localparam logic [2:0] OP_MERGE_UP   = 3'd6;

    // Command broadcast to every hole cell
    typedef struct packed {
        logic [2:0]        op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] len;
    } hole_cmd_t;

    // Read-back of one hole cell plus the position of the last inserted hole
    typedef struct packed {
        logic              valid;
        logic              joins;
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] len;
        logic [POS_W-1:0]  mark_pos;
    } hole_view_t;

endpackage

/* hdl/ffa_cell.sv */
`timescale 1ns / 1ps

module ffa_cell
    import ffa_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int AB = DEF_ADDRESS_BITS,
    parameter logic [AB-1:0] RESET_TOP = '0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  hole_cmd_t     cmd,
    input  logic          prev_ge,
    input  logic          prev_valid,
    input  logic [AB-1:0] prev_top,
    input  logic [AB-1:0] prev_len,
    input  logic          next_valid,
    input  logic          next_mark,
    input  logic [AB-1:0] next_top,
    input  logic [AB-1:0] next_len,
    output logic          valid,
    output logic          mark,
    output logic [AB-1:0] top,
    output logic [AB-1:0] len,
    output logic          ge,
    output logic          joins
);

    logic          valid_reg, valid_next;
    logic          mark_reg, mark_next;
    logic [AB-1:0] top_reg, top_next;
    logic [AB-1:0] len_reg, len_next;
    logic          is_pos, at_or_above, below_pos;
    logic [AB-1:0] cmd_top, cmd_len;

    assign cmd_top = cmd.top[AB-1:0];
    assign cmd_len = cmd.len[AB-1:0];
    assign is_pos      = (POS_W'(INDEX) == cmd.pos);
    assign at_or_above = (POS_W'(INDEX) >= cmd.pos);
    assign below_pos   = (POS_W'(INDEX + 1) == cmd.pos);

    // Local flags seen by the neighbors and the controller
    assign ge    = valid_reg && (top_reg > cmd_top);
    assign joins = valid_reg && next_valid && ((top_reg - len_reg) == next_top);

    // Apply the broadcast command to this entry
    always_comb
    begin
        valid_next = valid_reg;
        mark_next  = mark_reg;
        top_next   = top_reg;
        len_next   = len_reg;
        case (cmd.op)
            OP_INIT:
            begin
                mark_next = 1'b0;
                if (INDEX == 0)
                begin
                    top_next   = cmd_top;
                    len_next   = cmd_top;
                    valid_next = (cmd_top != '0);
                end
                else
                begin
                    top_next   = '0;
                    len_next   = '0;
                    valid_next = 1'b0;
                end
            end
            OP_INSERT:
            begin
                mark_next = 1'b0;
                if (!ge)
                begin
                    if (prev_ge)
                    begin
                        top_next   = cmd_top;
                        len_next   = cmd_len;
                        valid_next = 1'b1;
                        mark_next  = 1'b1;
                    end
                    else
                    begin
                        top_next   = prev_top;
                        len_next   = prev_len;
                        valid_next = prev_valid;
                    end
                end
            end
            OP_DELETE:
            begin
                if (at_or_above)
                begin
                    top_next   = next_top;
                    len_next   = next_len;
                    valid_next = next_valid;
                    mark_next  = next_mark;
                end
            end
            OP_SHRINK:
            begin
                if (is_pos)
                begin
                    top_next = top_reg - cmd_len;
                    len_next = len_reg - cmd_len;
                end
            end
            OP_MERGE_DOWN:
            begin
                if (is_pos)
                begin
                    len_next = len_reg + next_len;
                end
                else if (at_or_above)
                begin
                    top_next   = next_top;
                    len_next   = next_len;
                    valid_next = next_valid;
                    mark_next  = next_mark;
                end
            end
            OP_MERGE_UP:
            begin
                if (below_pos)
                begin
                    len_next = len_reg + next_len;
                end
                else if (at_or_above)
                begin
                    top_next   = next_top;
                    len_next   = next_len;
                    valid_next = next_valid;
                    mark_next  = next_mark;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= (INDEX == 0) && (RESET_TOP != '0);
            mark_reg  <= 1'b0;
            top_reg   <= (INDEX == 0) ? RESET_TOP : '0;
            len_reg   <= (INDEX == 0) ? RESET_TOP : '0;
        end
        else
        begin
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
            top_reg   <= top_next;
            len_reg   <= len_next;
        end
    end

    assign valid = valid_reg;
    assign mark  = mark_reg;
    assign top   = top_reg;
    assign len   = len_reg;

endmodule

/* hdl/ffa_chain.sv */
`timescale 1ns / 1ps

module ffa_chain
    import ffa_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_SLOTS + 1,
    parameter int AB = DEF_ADDRESS_BITS,
    parameter logic [AB-1:0] INIT_SIZE = '0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  hole_cmd_t        cmd,
    input  logic [POS_W-1:0] rd_idx,
    output hole_view_t       view
);

    logic          valid_w [DEPTH];
    logic          mark_w  [DEPTH];
    logic          ge_w    [DEPTH];
    logic          joins_w [DEPTH];
    logic [AB-1:0] top_w   [DEPTH];
    logic [AB-1:0] len_w   [DEPTH];

    // Row of hole cells, sorted by descending top address from cell 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic          p_ge, p_valid, n_valid, n_mark;
        logic [AB-1:0] p_top, p_len, n_top, n_len;

        if (i == 0)
        begin : g_head
            assign p_ge    = 1'b1;
            assign p_valid = 1'b0;
            assign p_top   = '0;
            assign p_len   = '0;
        end
        else
        begin : g_body
            assign p_ge    = ge_w[i-1];
            assign p_valid = valid_w[i-1];
            assign p_top   = top_w[i-1];
            assign p_len   = len_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign n_valid = 1'b0;
            assign n_mark  = 1'b0;
            assign n_top   = '0;
            assign n_len   = '0;
        end
        else
        begin : g_inner
            assign n_valid = valid_w[i+1];
            assign n_mark  = mark_w[i+1];
            assign n_top   = top_w[i+1];
            assign n_len   = len_w[i+1];
        end

        ffa_cell #(
            .INDEX     (i),
            .AB        (AB),
            .RESET_TOP (INIT_SIZE)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .prev_ge    (p_ge),
            .prev_valid (p_valid),
            .prev_top   (p_top),
            .prev_len   (p_len),
            .next_valid (n_valid),
            .next_mark  (n_mark),
            .next_top   (n_top),
            .next_len   (n_len),
            .valid      (valid_w[i]),
            .mark       (mark_w[i]),
            .top        (top_w[i]),
            .len        (len_w[i]),
            .ge         (ge_w[i]),
            .joins      (joins_w[i])
        );
    end

    // Read back the addressed cell and locate the marked one
    always_comb
    begin
        view = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (POS_W'(i) == rd_idx)
            begin
                view.valid = view.valid | valid_w[i];
                view.joins = view.joins | joins_w[i];
                view.top   = view.top | DATA_W'(top_w[i]);
                view.len   = view.len | DATA_W'(len_w[i]);
            end
            if (mark_w[i])
            begin
                view.mark_pos = view.mark_pos | POS_W'(i);
            end
        end
    end

endmodule

/* hdl/ffa_ctrl.sv */
`timescale 1ns / 1ps

module ffa_ctrl
    import ffa_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int AB = DEF_ADDRESS_BITS,
    parameter logic [AB-1:0] INIT_SIZE = '0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata,
    output hole_cmd_t             cmd,
    output logic [POS_W-1:0]      rd_idx,
    input  hole_view_t            view
);

    localparam int N  = MAX_SLOTS + 1;
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int UW = $clog2(N + 1);
    localparam int RW = $clog2(MAX_SLOTS + 1);
    localparam int CW = (AB > 16) ? AB : 16;
    localparam logic [63:0] LIMIT = (64'd1 << AB) - 64'd1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_VSCAN = 4'd2;
    localparam logic [3:0] S_VDEC  = 4'd3;
    localparam logic [3:0] S_FREAD = 4'd4;
    localparam logic [3:0] S_FREL  = 4'd5;
    localparam logic [3:0] S_RINS  = 4'd6;
    localparam logic [3:0] S_RPOS  = 4'd7;
    localparam logic [3:0] S_RMD   = 4'd8;
    localparam logic [3:0] S_RMU   = 4'd9;
    localparam logic [3:0] S_RDONE = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    function automatic logic [AB-1:0] sat_size(input logic [15:0] v);
        if (64'(v) > LIMIT)
            return AB'(LIMIT);
        return AB'(v);
    endfunction

    // Slot tables
    logic [AB-1:0] mem_top  [MAX_SLOTS];
    logic [AB-1:0] mem_len  [MAX_SLOTS];
    logic [31:0]   mem_time [MAX_SLOTS];
    logic [AB-1:0] mem_rd_top, mem_rd_len;
    logic [31:0]   mem_rd_time;
    logic          mem_we;
    logic [SW-1:0] mem_raddr;
    logic [AB-1:0] mem_wtop;

    logic [3:0]           state_reg, state_next;
    logic [15:0]          mem_size_reg, mem_size_next;
    logic [UW-1:0]        used_reg, used_next;
    logic [RW-1:0]        res_reg, res_next;
    logic [MAX_SLOTS-1:0] resident_reg, resident_next;
    logic [5:0]           slot6_reg, slot6_next;
    logic [SW-1:0]        slot_reg, slot_next;
    logic [15:0]          req_reg, req_next;
    logic [31:0]          time_reg, time_next;
    logic [UW-1:0]        f_reg, f_next;
    logic [SW-1:0]        k_reg, k_next;
    logic [RW-1:0]        vs_reg, vs_next;
    logic                 pend_reg, pend_next;
    logic [SW-1:0]        vsd_reg, vsd_next;
    logic                 best_valid_reg, best_valid_next;
    logic [SW-1:0]        best_slot_reg, best_slot_next;
    logic [AB-1:0]        best_top_reg, best_top_next;
    logic [AB-1:0]        best_len_reg, best_len_next;
    logic [31:0]          best_time_reg, best_time_next;
    logic [AB-1:0]        rel_top_reg, rel_top_next;
    logic [AB-1:0]        rel_len_reg, rel_len_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 evict_reg, evict_next;
    logic [1:0]           e_status_reg, e_status_next;
    logic [5:0]           e_slot_reg, e_slot_next;
    logic [15:0]          e_addr_reg, e_addr_next;
    logic                 e_last_reg, e_last_next;
    logic                 e_cont_reg, e_cont_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]           m_tuser_reg, m_tuser_next;
    logic                 m_tlast_reg, m_tlast_next;

    logic [5:0]    in_slot;
    logic [15:0]   in_req;
    logic [31:0]   in_now;
    logic          in_range;
    logic [SW-1:0] in_idx;
    logic [AB-1:0] sz_cur, sz_cfg;
    logic [AB-1:0] view_top, view_len;
    logic          better;

    assign in_slot  = s_tdata[5:0];
    assign in_req   = s_tdata[21:6];
    assign in_now   = s_tdata[53:22];
    assign in_range = (9'(in_slot) < 9'(MAX_SLOTS));
    assign in_idx   = SW'(in_slot);
    assign sz_cur   = sat_size(mem_size_reg);
    assign sz_cfg   = sat_size(cfg_wdata);
    assign view_top = view.top[AB-1:0];
    assign view_len = view.len[AB-1:0];
    assign mem_wtop = view_top;

    // Victim order: larger length wins, then older time stamp
    assign better = !best_valid_reg || (mem_rd_len > best_len_reg) ||
                    ((mem_rd_len == best_len_reg) && (mem_rd_time < best_time_reg));

    // Sequence one request
    always_comb
    begin
        state_next      = state_reg;
        mem_size_next   = mem_size_reg;
        used_next       = used_reg;
        res_next        = res_reg;
        resident_next   = resident_reg;
        slot6_next      = slot6_reg;
        slot_next       = slot_reg;
        req_next        = req_reg;
        time_next       = time_reg;
        f_next          = f_reg;
        k_next          = k_reg;
        vs_next         = vs_reg;
        pend_next       = pend_reg;
        vsd_next        = vsd_reg;
        best_valid_next = best_valid_reg;
        best_slot_next  = best_slot_reg;
        best_top_next   = best_top_reg;
        best_len_next   = best_len_reg;
        best_time_next  = best_time_reg;
        rel_top_next    = rel_top_reg;
        rel_len_next    = rel_len_reg;
        pos_next        = pos_reg;
        evict_next      = evict_reg;
        e_status_next   = e_status_reg;
        e_slot_next     = e_slot_reg;
        e_addr_next     = e_addr_reg;
        e_last_next     = e_last_reg;
        e_cont_next     = e_cont_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;
        cmd             = '0;
        cmd.op          = OP_HOLD;
        rd_idx          = '0;
        mem_we          = 1'b0;
        mem_raddr       = slot_reg;
        s_tready        = (state_reg == S_IDLE) && !cfg_we;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    // Re-initialise the whole memory
                    mem_size_next = cfg_wdata;
                    cmd.op        = OP_INIT;
                    cmd.top       = DATA_W'(sz_cfg);
                    used_next     = (sz_cfg != '0) ? UW'(1) : '0;
                    resident_next = '0;
                    res_next      = '0;
                end
                else if (s_tvalid)
                begin
                    slot6_next    = in_slot;
                    slot_next     = in_idx;
                    req_next      = in_req;
                    time_next     = in_now;
                    f_next        = '0;
                    k_next        = '0;
                    e_status_next = ST_ERROR;
                    e_slot_next   = in_slot;
                    e_addr_next   = '0;
                    e_last_next   = 1'b1;
                    e_cont_next   = 1'b0;
                    state_next    = S_EMIT;
                    if (in_range)
                    begin
                        if (s_tuser == KIND_FREE)
                        begin
                            if (resident_reg[in_idx])
                                state_next = S_FREAD;
                        end
                        else if (!resident_reg[in_idx] && (in_req != '0) &&
                                 (CW'(in_req) <= CW'(sz_cur)))
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                // Walk the hole list from the highest address
                rd_idx = POS_W'(f_reg);
                if ((f_reg >= used_reg) || !view.valid)
                begin
                    vs_next         = '0;
                    pend_next       = 1'b0;
                    best_valid_next = 1'b0;
                    state_next      = S_VSCAN;
                end
                else if (CW'(view_len) >= CW'(req_reg))
                begin
                    cmd.pos = POS_W'(f_reg);
                    cmd.len = DATA_W'(req_reg);
                    if (CW'(view_len) == CW'(req_reg))
                    begin
                        cmd.op    = OP_DELETE;
                        used_next = used_reg - UW'(1);
                    end
                    else
                    begin
                        cmd.op = OP_SHRINK;
                    end
                    mem_we                  = 1'b1;
                    resident_next[slot_reg] = 1'b1;
                    res_next                = res_reg + RW'(1);
                    e_status_next           = ST_PLACED;
                    e_slot_next             = slot6_reg;
                    e_addr_next             = 16'(view_top);
                    e_last_next             = 1'b1;
                    e_cont_next             = 1'b0;
                    state_next              = S_EMIT;
                end
                else
                begin
                    f_next = f_reg + UW'(1);
                end
            end
            S_VSCAN:
            begin
                // Stream the slot tables and keep the best victim
                mem_raddr = SW'(vs_reg);
                if (pend_reg && resident_reg[vsd_reg] && better)
                begin
                    best_valid_next = 1'b1;
                    best_slot_next  = vsd_reg;
                    best_top_next   = mem_rd_top;
                    best_len_next   = mem_rd_len;
                    best_time_next  = mem_rd_time;
                end
                pend_next = (vs_reg != RW'(MAX_SLOTS));
                vsd_next  = SW'(vs_reg);
                if (vs_reg != RW'(MAX_SLOTS))
                    vs_next = vs_reg + RW'(1);
                else if (!pend_reg)
                    state_next = S_VDEC;
            end
            S_VDEC:
            begin
                if (!best_valid_reg || (32'(k_reg) >= 32'(MAX_SLOTS - 1)))
                begin
                    e_status_next = ST_ERROR;
                    e_slot_next   = slot6_reg;
                    e_addr_next   = '0;
                    e_last_next   = 1'b1;
                    e_cont_next   = 1'b0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    resident_next[best_slot_reg] = 1'b0;
                    res_next     = res_reg - RW'(1);
                    rel_top_next = best_top_reg;
                    rel_len_next = best_len_reg;
                    evict_next   = 1'b1;
                    state_next   = S_RINS;
                end
            end
            S_FREAD:
            begin
                mem_raddr  = slot_reg;
                state_next = S_FREL;
            end
            S_FREL:
            begin
                resident_next[slot_reg] = 1'b0;
                res_next     = res_reg - RW'(1);
                rel_top_next = mem_rd_top;
                rel_len_next = mem_rd_len;
                evict_next   = 1'b0;
                state_next   = S_RINS;
            end
            S_RINS:
            begin
                // Insert the released region in address order; drop it if full
                if (used_reg < UW'(N))
                begin
                    cmd.op     = OP_INSERT;
                    cmd.top    = DATA_W'(rel_top_reg);
                    cmd.len    = DATA_W'(rel_len_reg);
                    used_next  = used_reg + UW'(1);
                    state_next = S_RPOS;
                end
                else
                begin
                    state_next = S_RDONE;
                end
            end
            S_RPOS:
            begin
                pos_next   = view.mark_pos;
                state_next = S_RMD;
            end
            S_RMD:
            begin
                // Merge with the hole directly below
                rd_idx = pos_reg;
                if (view.joins)
                begin
                    cmd.op    = OP_MERGE_DOWN;
                    cmd.pos   = pos_reg;
                    used_next = used_reg - UW'(1);
                end
                state_next = S_RMU;
            end
            S_RMU:
            begin
                // Merge with the hole directly above
                rd_idx = pos_reg - POS_W'(1);
                if ((pos_reg != '0) && view.joins)
                begin
                    cmd.op    = OP_MERGE_UP;
                    cmd.pos   = pos_reg;
                    used_next = used_reg - UW'(1);
                end
                state_next = S_RDONE;
            end
            S_RDONE:
            begin
                if (evict_reg)
                begin
                    e_status_next = ST_EVICTED;
                    e_slot_next   = 6'(best_slot_reg);
                    e_addr_next   = 16'(best_top_reg);
                    e_last_next   = 1'b0;
                    e_cont_next   = 1'b1;
                end
                else
                begin
                    e_status_next = ST_FREED;
                    e_slot_next   = slot6_reg;
                    e_addr_next   = 16'(rel_top_reg);
                    e_last_next   = 1'b1;
                    e_cont_next   = 1'b0;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // Hand the result to the output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = e_status_reg;
                    m_tlast_next  = e_last_reg;
                    m_tdata_next  = {4'b0, 7'(res_reg), 7'(used_reg), e_addr_reg, e_slot_reg};
                    if (e_cont_reg)
                    begin
                        k_next     = k_reg + SW'(1);
                        f_next     = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Slot table write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_top[slot_reg]  <= mem_wtop;
            mem_len[slot_reg]  <= AB'(req_reg);
            mem_time[slot_reg] <= time_reg;
        end
        mem_rd_top  <= mem_top[mem_raddr];
        mem_rd_len  <= mem_len[mem_raddr];
        mem_rd_time <= mem_time[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mem_size_reg   <= RESET_MEMORY_SIZE;
            used_reg       <= (INIT_SIZE != '0) ? UW'(1) : '0;
            res_reg        <= '0;
            resident_reg   <= '0;
            pend_reg       <= 1'b0;
            best_valid_reg <= 1'b0;
            evict_reg      <= 1'b0;
            e_cont_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mem_size_reg   <= mem_size_next;
            used_reg       <= used_next;
            res_reg        <= res_next;
            resident_reg   <= resident_next;
            pend_reg       <= pend_next;
            best_valid_reg <= best_valid_next;
            evict_reg      <= evict_next;
            e_cont_reg     <= e_cont_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        slot6_reg     <= slot6_next;
        slot_reg      <= slot_next;
        req_reg       <= req_next;
        time_reg      <= time_next;
        f_reg         <= f_next;
        k_reg         <= k_next;
        vs_reg        <= vs_next;
        vsd_reg       <= vsd_next;
        best_slot_reg <= best_slot_next;
        best_top_reg  <= best_top_next;
        best_len_reg  <= best_len_next;
        best_time_reg <= best_time_next;
        rel_top_reg   <= rel_top_next;
        rel_len_reg   <= rel_len_next;
        pos_reg       <= pos_next;
        e_status_reg  <= e_status_next;
        e_slot_reg    <= e_slot_next;
        e_addr_reg    <= e_addr_next;
        e_last_reg    <= e_last_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
        m_tlast_reg   <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* hdl/first_fit_allocator_with_eviction.sv */
`timescale 1ns / 1ps
// First-fit allocator with eviction of the largest resident slot.
// Requests enter on the s_ stream: tuser is the kind (allocate or free),
// tdata carries slot, size and time stamp. Results leave on the m_ stream:
// tuser is the status, tdata carries slot, top address, hole and resident
// counts, and tlast marks the final result of a request.
// The memory size register is written through cfg_we/cfg_wdata while the
// block is idle; every write re-initialises it to one hole (none for a zero size), no slot resident.
// One request is worked at a time. An error goes straight to the result; a free
// reads the slot table, releases the region, inserts it and merges it with its
// neighbours. An allocate walks the hole cells one per cycle; each eviction adds
// a sweep of the slot tables and steps to pick the victim, release it and hand
// out its result before the walk repeats.
// Reset sets the size to 1024 units with a single hole and takes effect at
// once. A result waits in the output register while m_tready is low; the
// block stalls on its next result until the register is free, and
// s_tready stays low until the request is finished.

module first_fit_allocator_with_eviction
    import ffa_pkg::*;
#(
    parameter int MAX_SLOTS    = DEF_MAX_SLOTS,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // slot[5:0], req_size[21:6], now_time[53:22]
    input  logic                  s_tuser,   // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // result_slot[5:0], result_address[21:6],
                                             // hole_count[28:22], resident_count[35:29]
    output logic [1:0]            m_tuser,   // status
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata
);

    localparam logic [63:0] LIMIT = (64'd1 << ADDRESS_BITS) - 64'd1;
    localparam logic [ADDRESS_BITS-1:0] INIT_SIZE =
        (64'(RESET_MEMORY_SIZE) > LIMIT) ? ADDRESS_BITS'(LIMIT)
                                         : ADDRESS_BITS'(RESET_MEMORY_SIZE);

    hole_cmd_t        cmd;
    hole_view_t       view;
    logic [POS_W-1:0] rd_idx;

    ffa_chain #(
        .DEPTH     (MAX_SLOTS + 1),
        .AB        (ADDRESS_BITS),
        .INIT_SIZE (INIT_SIZE)
    ) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .rd_idx (rd_idx),
        .view   (view)
    );

    ffa_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .AB        (ADDRESS_BITS),
        .INIT_SIZE (INIT_SIZE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .rd_idx    (rd_idx),
        .view      (view)
    );

endmodule

/* sim/first_fit_allocator_with_eviction_check.sv */
`timescale 1ns / 1ps

module first_fit_allocator_with_eviction_check
    import ffa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [1:0]            m_tuser,
    input  logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata,
    output int                    fail_count,
    output int                    pending_count
);

    localparam int NSLOT = 64;
    localparam int NHOLE = NSLOT + 1;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic [15:0] addr;
        logic [6:0]  holes;
        logic [6:0]  residents;
        logic        last;
    } alloc_result_t;

    // Shadow copy of the allocator state
    logic [15:0] mem_size;
    logic [15:0] gap_top [NHOLE];
    logic [15:0] gap_len [NHOLE];
    int          gap_count;
    logic        owned [NSLOT];
    logic [15:0] own_top [NSLOT];
    logic [15:0] own_len [NSLOT];
    logic [31:0] own_stamp [NSLOT];

    alloc_result_t result_queue[$];

    assign pending_count = result_queue.size();

    function automatic int owned_count();
        int n;
        n = 0;
        for (int s = 0; s < NSLOT; s++)
            n += owned[s];
        return n;
    endfunction

    function automatic void clear_memory();
        for (int i = 0; i < NHOLE; i++)
        begin
            gap_top[i] = '0;
            gap_len[i] = '0;
        end
        for (int s = 0; s < NSLOT; s++)
            owned[s] = 1'b0;
        gap_top[0] = mem_size;
        gap_len[0] = mem_size;
        gap_count  = (mem_size != 0);
    endfunction

    function automatic void push_result(logic [1:0] st, logic [5:0] sl, logic [15:0] ad,
                                        logic lst);
        alloc_result_t r;
        r.status    = st;
        r.slot      = sl;
        r.addr      = ad;
        r.holes     = gap_count[6:0];
        r.residents = 7'(owned_count());
        r.last      = lst;
        result_queue.push_back(r);
    endfunction

    function automatic void remove_gap(int i);
        if (i >= gap_count)
            return;
        for (int j = i; j < gap_count - 1; j++)
        begin
            gap_top[j] = gap_top[j+1];
            gap_len[j] = gap_len[j+1];
        end
        gap_count--;
    endfunction

    // Return a slot's region to the ordered hole list and merge neighbors
    function automatic void return_region(int s);
        int i;
        i = 0;
        owned[s] = 1'b0;
        if (gap_count >= NHOLE)
            return;
        while (i < gap_count && gap_top[i] > own_top[s])
            i++;
        for (int j = gap_count; j > i; j--)
        begin
            gap_top[j] = gap_top[j-1];
            gap_len[j] = gap_len[j-1];
        end
        gap_top[i] = own_top[s];
        gap_len[i] = own_len[s];
        gap_count++;
        if (i + 1 < gap_count && gap_top[i] - gap_len[i] == gap_top[i+1])
        begin
            gap_len[i] += gap_len[i+1];
            remove_gap(i + 1);
        end
        if (i > 0 && gap_top[i-1] - gap_len[i-1] == gap_top[i])
        begin
            gap_len[i-1] += gap_len[i];
            remove_gap(i);
        end
    endfunction

    function automatic int choose_victim();
        int best;
        best = -1;
        for (int s = 0; s < NSLOT; s++)
        begin
            if (!owned[s])
                continue;
            if (best < 0 || own_len[s] > own_len[best] ||
                (own_len[s] == own_len[best] && own_stamp[s] < own_stamp[best]))
                best = s;
        end
        return best;
    endfunction

    // Work out every result that one request causes
    function automatic void predict_request(logic kind, logic [5:0] sl, logic [15:0] req,
                                            logic [31:0] stamp);
        int          f;
        int          v;
        int          evicted;
        logic [15:0] top;
        evicted = 0;
        if (kind == KIND_FREE)
        begin
            if (!owned[sl])
                push_result(ST_ERROR, sl, '0, 1'b1);
            else
            begin
                top = own_top[sl];
                return_region(sl);
                push_result(ST_FREED, sl, top, 1'b1);
            end
            return;
        end
        if (owned[sl] || req == 0 || req > mem_size)
        begin
            push_result(ST_ERROR, sl, '0, 1'b1);
            return;
        end
        forever
        begin
            f = 0;
            while (f < gap_count && gap_len[f] < req)
                f++;
            if (f < gap_count)
            begin
                top = gap_top[f];
                if (gap_len[f] == req)
                    remove_gap(f);
                else
                begin
                    gap_top[f] -= req;
                    gap_len[f] -= req;
                end
                owned[sl]     = 1'b1;
                own_top[sl]   = top;
                own_len[sl]   = req;
                own_stamp[sl] = stamp;
                push_result(ST_PLACED, sl, top, 1'b1);
                return;
            end
            v = choose_victim();
            if (v < 0 || evicted >= NSLOT - 1)
            begin
                push_result(ST_ERROR, sl, '0, 1'b1);
                return;
            end
            top = own_top[v];
            return_region(v);
            push_result(ST_EVICTED, v[5:0], top, 1'b0);
            evicted++;
        end
    endfunction

    // Track config writes and requests; compare each result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        alloc_result_t got;
        if (!rst_n)
        begin
            fail_count <= 0;
            mem_size = RESET_MEMORY_SIZE;
            clear_memory();
            result_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                mem_size = cfg_wdata;
                clear_memory();
            end
            if (m_tvalid && m_tready)
            begin
                got.status    = m_tuser;
                got.slot      = m_tdata[5:0];
                got.addr      = m_tdata[21:6];
                got.holes     = m_tdata[28:22];
                got.residents = m_tdata[35:29];
                got.last      = m_tlast;
                if (result_queue.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: result mismatch expected st=%0d slot=%0d addr=%0d holes=%0d res=%0d last=%0d actual st=%0d slot=%0d addr=%0d holes=%0d res=%0d last=%0d",
                            $time, want.status, want.slot, want.addr, want.holes,
                            want.residents, want.last, got.status, got.slot, got.addr,
                            got.holes, got.residents, got.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata[5:0], s_tdata[21:6], s_tdata[53:22]);
        end
    end

endmodule

/* sim/first_fit_allocator_with_eviction_test.sv */
`timescale 1ns / 1ps

module first_fit_allocator_with_eviction_test;
    import ffa_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [15:0]           cfg_wdata;
    int                    fail_count;
    int                    pending_count;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    quiet_cycles;
    logic [15:0]           cur_size;

    first_fit_allocator_with_eviction u_top (.*);

    first_fit_allocator_with_eviction_check u_check (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver stalls at random
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Hold valid until accepted; drop it only while idling before the next request
    task automatic send_request(logic kind, logic [5:0] sl, logic [15:0] req, logic [31:0] stamp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b0, stamp, req, sl};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_size(logic [15:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        cur_size = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly allocations sized to force evictions, with frees mixed in
    task automatic random_requests(int count);
        logic [15:0] req;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0:       req = 16'($urandom);
                1:       req = cur_size;
                default: req = 16'($urandom_range(1, (cur_size > 4) ? cur_size / 4 : 1));
            endcase
            send_request(($urandom_range(2) == 0) ? KIND_FREE : KIND_ALLOC,
                         6'($urandom_range(63)), req, $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        quiet_cycles = 0;
        send_idle_pct = 34;
        recv_idle_pct = 81;
        cur_size = RESET_MEMORY_SIZE;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset size, errors, exact fit, eviction, merge on free
        send_request(KIND_ALLOC, 6'd0, 16'd0, 32'd5);
        send_request(KIND_ALLOC, 6'd1, 16'd1025, 32'd5);
        send_request(KIND_FREE, 6'd2, 16'd0, 32'd0);
        send_request(KIND_ALLOC, 6'd63, 16'd400, 32'hFFFF_FFFF);
        send_request(KIND_ALLOC, 6'd63, 16'd10, 32'd1);
        send_request(KIND_ALLOC, 6'd5, 16'd400, 32'd0);
        send_request(KIND_ALLOC, 6'd6, 16'd224, 32'd2);
        send_request(KIND_ALLOC, 6'd7, 16'd500, 32'd3);
        send_request(KIND_FREE, 6'd6, 16'hFFFF, 32'd0);
        send_request(KIND_ALLOC, 6'd8, 16'd1024, 32'd4);
        send_request(KIND_FREE, 6'd8, 16'd0, 32'd0);
        write_size(16'd0);
        send_request(KIND_ALLOC, 6'd3, 16'd1, 32'd0);
        write_size(16'hFFFF);
        send_request(KIND_ALLOC, 6'd4, 16'hFFFF, 32'hAAAA_5555);
        send_request(KIND_ALLOC, 6'd9, 16'h8000, 32'h5555_AAAA);
        write_size(16'd1);
        send_request(KIND_ALLOC, 6'd42, 16'd1, 32'd0);
        send_request(KIND_ALLOC, 6'd21, 16'd1, 32'd1);
        send_request(KIND_FREE, 6'd21, 16'd0, 32'd0);

        write_size(16'd200);
        random_requests(130);
        send_idle_pct = 81;
        recv_idle_pct = 34;
        write_size(16'd1024);
        random_requests(130);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_size(16'd4000);
        random_requests(130);

        drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
